// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the priority FIFO RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication or sequence property on every rising clock edge outside reset.
`define TLPF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define TLPF_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/tlpf_pkg.sv =====
// Shared types and constants for the three-level priority FIFO.
// No dependencies; imported by every module of the block.
package tlpf_pkg;

    localparam int DEPTH_DEF  = 8;
    localparam int LEVELS_DEF = 3;

    localparam int FUNC_W    = 1;
    localparam int LEVEL_W   = 2;
    localparam int ELEM_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int IN_DATA_W  = 16;  // level, element, zero fill
    localparam int OUT_DATA_W = 16;  // removed_element, served_level, zero fill

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    // Decision of the queue control for one item
    typedef struct packed {
        logic                 wr_en;
        logic                 rd_en;
        t_status              status;
        logic [LEVEL_W-1:0]   served;
    } t_ctl;

endpackage

// ===== rtl/core/three_level_priority_fifo.sv =====
// Priority queue of per-level circular byte FIFOs, level 1 served first.
// An item is registered in the input stage, then its result in the result stage, held while output stalls.
// Throughput: one item per cycle while the output does not stall; the store has one port used per item.
// Reset clears all fill counts and heads; the element store is not cleared.
// Depends on tlpf_pkg, tlpf_ctrl, tlpf_mem and assert_macros.svh.
`include "assert_macros.svh"
module three_level_priority_fifo #(
    parameter int DEPTH  = tlpf_pkg::DEPTH_DEF,
    parameter int LEVELS = tlpf_pkg::LEVELS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [tlpf_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,  // level[1:0], element[9:2]
    input  logic [tlpf_pkg::FUNC_W-1:0]       i_s_axis_tuser,  // func[0]
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [tlpf_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,  // removed_element[7:0], served_level[9:8]
    output logic [tlpf_pkg::STATUS_W-1:0]     o_m_axis_tuser   // status[1:0]
);
    import tlpf_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH * LEVELS);

    // input stage
    logic                r_v1;
    t_func               r_func;
    logic [LEVEL_W-1:0]  r_level;
    logic [ELEM_W-1:0]   r_element;
    // result stage
    logic                r_v2;
    t_status             r_status;
    logic [LEVEL_W-1:0]  r_served;
    logic                r_take;

    logic                adv;
    logic                in_xfer;
    t_ctl                ctl;
    logic [ADDR_W-1:0]   addr;
    logic [ELEM_W-1:0]   rd_data;

    assign adv             = r_v1 && (!r_v2 || i_m_axis_tready);
    assign o_s_axis_tready = !r_v1 || adv;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_v1 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_func    <= t_func'(i_s_axis_tuser);
            r_level   <= i_s_axis_tdata[LEVEL_W-1:0];
            r_element <= i_s_axis_tdata[LEVEL_W +: ELEM_W];
        end
    end

    tlpf_ctrl #(
        .DEPTH  (DEPTH),
        .LEVELS (LEVELS),
        .ADDR_W (ADDR_W)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_func  (r_func),
        .i_level (r_level),
        .o_ctl   (ctl),
        .o_addr  (addr)
    );

    tlpf_mem #(
        .ENTRIES (DEPTH * LEVELS),
        .ADDR_W  (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (ctl.wr_en),
        .i_rd_en   (ctl.rd_en),
        .i_addr    (addr),
        .i_wr_data (r_element),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v2 <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_v2 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_status <= ctl.status;
            r_served <= ctl.served;
            r_take   <= ctl.rd_en;
        end
    end

    assign o_m_axis_tvalid = r_v2;
    assign o_m_axis_tuser  = r_status;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - ELEM_W - LEVEL_W){1'b0}}, r_served,
                              (r_take ? rd_data : {ELEM_W{1'b0}})};

    `TLPF_ASSERT(a_take_ok, i_clk, i_rst_n, r_v2 && r_take |-> r_status == ST_OK, "removal without ok status")
    `TLPF_ASSERT(a_adv_result, i_clk, i_rst_n, adv |=> r_v2, "advanced item left no result")

endmodule

// ===== rtl/core/tlpf_mem.sv =====
// Element store for all levels: one write port, one registered read port.
// Depends on tlpf_pkg for the element width.
module tlpf_mem #(
    parameter int ENTRIES = tlpf_pkg::DEPTH_DEF * tlpf_pkg::LEVELS_DEF,
    parameter int ADDR_W  = $clog2(ENTRIES)
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic                          i_rd_en,
    input  logic [ADDR_W-1:0]             i_addr,
    input  logic [tlpf_pkg::ELEM_W-1:0]   i_wr_data,
    output logic [tlpf_pkg::ELEM_W-1:0]   o_rd_data
);
    import tlpf_pkg::*;

    logic [ELEM_W-1:0] r_mem [ENTRIES];
    logic [ELEM_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
    end

    // hold read data while no remove advances
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/tlpf_ctrl.sv =====
// Per-level head and fill tracking, priority select and store addressing.
// Depends on tlpf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tlpf_ctrl #(
    parameter int DEPTH  = tlpf_pkg::DEPTH_DEF,
    parameter int LEVELS = tlpf_pkg::LEVELS_DEF,
    parameter int ADDR_W = $clog2(DEPTH * LEVELS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  tlpf_pkg::t_func               i_func,
    input  logic [tlpf_pkg::LEVEL_W-1:0]  i_level,
    output tlpf_pkg::t_ctl                o_ctl,
    output logic [ADDR_W-1:0]             o_addr
);
    import tlpf_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int SUM_W = PTR_W + 1;

    logic [PTR_W-1:0]  r_head [LEVELS];
    logic [CNT_W-1:0]  r_fill [LEVELS];
    logic [PTR_W-1:0]  n_head [LEVELS];
    logic [CNT_W-1:0]  n_fill [LEVELS];

    logic [LEVELS-1:0] is_ins;
    logic [LEVELS-1:0] full;
    logic [LEVELS-1:0] nonempty;
    logic [LEVELS-1:0] sel;
    logic [LEVELS-1:0] wr_q;
    logic [LEVELS-1:0] rd_q;
    logic [ADDR_W-1:0] addr_q [LEVELS];
    logic [LEVEL_W-1:0] served_q [LEVELS];
    logic              is_rem;

    assign is_rem = (i_func == FUNC_REMOVE);

    for (genvar q = 0; q < LEVELS; q++) begin : g_lane
        localparam logic [3:0] LV = 4'(q + 1);
        logic [SUM_W-1:0] sum;
        logic [PTR_W-1:0] tail;
        logic             head_last;

        assign is_ins[q]   = (i_func == FUNC_INSERT) && ({2'b00, i_level} == LV);
        assign full[q]     = (r_fill[q] == CNT_W'(DEPTH));
        assign nonempty[q] = (r_fill[q] != '0);
        assign wr_q[q]     = is_ins[q] && !full[q];
        assign rd_q[q]     = is_rem && sel[q];

        assign sum  = SUM_W'(r_head[q]) + SUM_W'(r_fill[q]);
        assign tail = (sum >= SUM_W'(DEPTH)) ? PTR_W'(sum - SUM_W'(DEPTH)) : PTR_W'(sum);
        assign head_last = (r_head[q] == PTR_W'(DEPTH - 1));

        assign addr_q[q]   = ADDR_W'(q * DEPTH) + ADDR_W'(rd_q[q] ? r_head[q] : tail);
        assign served_q[q] = LEVEL_W'(q + 1);

        always_comb begin
            n_head[q] = r_head[q];
            n_fill[q] = r_fill[q];
            if (i_adv && wr_q[q]) begin
                n_fill[q] = r_fill[q] + 1'b1;
            end else if (i_adv && rd_q[q]) begin
                n_fill[q] = r_fill[q] - 1'b1;
                // an emptied level restarts at slot zero; the head also wraps to zero after the last slot
                if (r_fill[q] == CNT_W'(1) || head_last) begin
                    n_head[q] = '0;
                end else begin
                    n_head[q] = r_head[q] + 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_head[q] <= '0;
                r_fill[q] <= '0;
            end else begin
                r_head[q] <= n_head[q];
                r_fill[q] <= n_fill[q];
            end
        end

        `TLPF_NEVER(a_fill_bound, i_clk, i_rst_n, r_fill[q] > CNT_W'(DEPTH), "fill above depth")
        `TLPF_ASSERT(a_empty_head, i_clk, i_rst_n, (r_fill[q] == '0) |-> (r_head[q] == '0), "empty level with nonzero head")
    end

    // first non-empty level wins
    always_comb begin
        logic seen;
        seen = 1'b0;
        for (int q = 0; q < LEVELS; q++) begin
            sel[q] = nonempty[q] && !seen;
            seen   = seen || nonempty[q];
        end
    end

    always_comb begin
        o_addr       = '0;
        o_ctl.served = '0;
        for (int q = 0; q < LEVELS; q++) begin
            if (wr_q[q] || rd_q[q]) begin
                o_addr = o_addr | addr_q[q];
            end
            if (rd_q[q]) begin
                o_ctl.served = o_ctl.served | served_q[q];
            end
        end
    end

    assign o_ctl.wr_en = i_adv && (|wr_q);
    assign o_ctl.rd_en = i_adv && (|rd_q);

    always_comb begin
        if (is_rem) begin
            o_ctl.status = (|nonempty) ? ST_OK : ST_EMPTY;
        end else if (!(|is_ins)) begin
            o_ctl.status = ST_INVALID;
        end else if (|(is_ins & full)) begin
            o_ctl.status = ST_FULL;
        end else begin
            o_ctl.status = ST_OK;
        end
    end

    `TLPF_NEVER(a_wr_rd_excl, i_clk, i_rst_n, o_ctl.wr_en && o_ctl.rd_en, "write and read in one cycle")
    `TLPF_ASSERT(a_one_served, i_clk, i_rst_n, $onehot0(rd_q), "more than one level served")

endmodule
